/* hw/rtl/ile_pkg.sv */
package ile_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CNT_O_W = 11;

	// input item layout, lowest bit first: cmd, position, value
	localparam int unsigned IN_CMD_LO = 0;
	localparam int unsigned IN_POS_LO = IN_CMD_LO + CMD_W;
	localparam int unsigned IN_VAL_LO = IN_POS_LO + POS_W;
	localparam int unsigned IN_BITS   = IN_VAL_LO + DATA_W;
	localparam int unsigned S_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	// result item layout, lowest bit first: read_value, status, entry_count
	localparam int unsigned OUT_RV_LO  = 0;
	localparam int unsigned OUT_ST_LO  = OUT_RV_LO + DATA_W;
	localparam int unsigned OUT_CNT_LO = OUT_ST_LO + STAT_W;
	localparam int unsigned OUT_BITS   = OUT_CNT_LO + CNT_O_W;
	localparam int unsigned M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_READ      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd4;

	localparam logic [STAT_W-1:0] STS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STS_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STS_FULL  = 2'd2;

endpackage

/* hw/rtl/ile_store.sv */
module ile_store #(
	parameter int unsigned DEPTH = ile_pkg::CAPACITY_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ile_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ile_pkg::DATA_W-1:0] rdata
);
	import ile_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/ile_ctrl.sv */
module ile_ctrl #(
	parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF,
	parameter int unsigned AW       = $clog2(CAPACITY)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ile_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ile_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [ile_pkg::DATA_W-1:0]    mem_wdata,
	output logic                         mem_re,
	output logic [AW-1:0]                mem_raddr,
	input  logic [ile_pkg::DATA_W-1:0]    mem_rdata
);
	import ile_pkg::*;

	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > CNT_O_W) ? CW : CNT_O_W;

	typedef enum logic [2:0] {
		IDLE,
		RD_WAIT,
		SHIFT,
		PUT_VAL,
		FINISH
	} state_t;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [AW-1:0]     tgt_q, tgt_d;
	logic              del_q, del_d;
	logic [DATA_W-1:0] val_q, val_d;
	logic [DATA_W-1:0] rv_q, rv_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic              mvalid_q, mvalid_d;
	logic [M_TDATA_W-1:0] mdata_q, mdata_d;

	logic [CMD_W-1:0]  in_cmd;
	logic [POS_W-1:0]  in_pos;
	logic [DATA_W-1:0] in_val;
	logic [CMPW-1:0]   pos_ext, cnt_ext;
	logic [AW-1:0]     pos_addr, cnt_addr, last_idx;
	logic              in_read, in_ins, full;
	logic              ins_go;
	logic [AW-1:0]     ins_tgt;
	logic [CMPW-1:0]   cnt_out;

	assign in_cmd = s_tdata[IN_CMD_LO +: CMD_W];
	assign in_pos = s_tdata[IN_POS_LO +: POS_W];
	assign in_val = s_tdata[IN_VAL_LO +: DATA_W];

	// position is only used as an address once known to be at most count
	assign pos_ext  = CMPW'(in_pos[POS_W-2:0]);
	assign cnt_ext  = CMPW'(count_q);
	assign pos_addr = pos_ext[AW-1:0];
	assign cnt_addr = AW'(count_q);
	assign last_idx = AW'(count_q - 1'b1);
	assign in_read  = !in_pos[POS_W-1] && (pos_ext < cnt_ext);
	assign in_ins   = !in_pos[POS_W-1] && (pos_ext <= cnt_ext);
	assign full     = (count_q == CW'(CAPACITY));
	assign cnt_out  = CMPW'(count_q);

	assign s_tready = (state_q == IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		tgt_d     = tgt_q;
		del_d     = del_q;
		val_d     = val_q;
		rv_d      = rv_q;
		st_d      = st_q;
		mvalid_d  = mvalid_q;
		mdata_d   = mdata_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		ins_go    = 1'b0;
		ins_tgt   = '0;

		if (mvalid_q && m_tready) begin
			mvalid_d = 1'b0;
		end

		unique case (state_q)
			IDLE: begin
				if (s_tvalid) begin
					val_d   = in_val;
					rv_d    = '0;
					st_d    = STS_DONE;
					state_d = FINISH;
					unique case (in_cmd)
						CMD_READ: begin
							if (in_read) begin
								mem_re    = 1'b1;
								mem_raddr = pos_addr;
								state_d   = RD_WAIT;
							end else begin
								rv_d = '1;
								st_d = STS_RANGE;
							end
						end
						CMD_INS_FRONT: begin
							if (full) st_d = STS_FULL;
							else ins_go = 1'b1;
						end
						CMD_APPEND: begin
							ins_tgt = cnt_addr;
							if (full) st_d = STS_FULL;
							else ins_go = 1'b1;
						end
						CMD_INS_POS: begin
							ins_tgt = pos_addr;
							if (!in_ins) st_d = STS_RANGE;
							else if (full) st_d = STS_FULL;
							else ins_go = 1'b1;
						end
						CMD_DELETE: begin
							if (!in_read) begin
								st_d = STS_RANGE;
							end else if (pos_addr == last_idx) begin
								count_d = count_q - 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = pos_addr + 1'b1;
								idx_d     = pos_addr + 1'b1;
								del_d     = 1'b1;
								state_d   = SHIFT;
							end
						end
						default: begin
						end
					endcase

					if (ins_go) begin
						if (ins_tgt == cnt_addr) begin
							// slot at the tail: nothing to move
							mem_we    = 1'b1;
							mem_waddr = ins_tgt;
							mem_wdata = in_val;
							count_d   = count_q + 1'b1;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = last_idx;
							idx_d     = last_idx;
							tgt_d     = ins_tgt;
							del_d     = 1'b0;
							state_d   = SHIFT;
						end
					end
				end
			end
			RD_WAIT: begin
				rv_d    = mem_rdata;
				state_d = FINISH;
			end
			SHIFT: begin
				// data read last cycle moves one slot; next read is two slots away
				mem_we = 1'b1;
				if (!del_q) begin
					mem_waddr = idx_q + 1'b1;
					if (idx_q == tgt_q) begin
						state_d = PUT_VAL;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q - 1'b1;
						idx_d     = idx_q - 1'b1;
					end
				end else begin
					mem_waddr = idx_q - 1'b1;
					if (idx_q == last_idx) begin
						count_d = count_q - 1'b1;
						state_d = FINISH;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_q + 1'b1;
						idx_d     = idx_q + 1'b1;
					end
				end
			end
			PUT_VAL: begin
				mem_we    = 1'b1;
				mem_waddr = tgt_q;
				mem_wdata = val_q;
				count_d   = count_q + 1'b1;
				state_d   = FINISH;
			end
			FINISH: begin
				if (!mvalid_q || m_tready) begin
					mvalid_d = 1'b1;
					mdata_d  = '0;
					mdata_d[OUT_RV_LO +: DATA_W]   = rv_q;
					mdata_d[OUT_ST_LO +: STAT_W]   = st_q;
					mdata_d[OUT_CNT_LO +: CNT_O_W] = cnt_out[CNT_O_W-1:0];
					state_d  = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			count_q  <= '0;
			mvalid_q <= 1'b0;
			idx_q    <= '0;
			tgt_q    <= '0;
			del_q    <= 1'b0;
			val_q    <= '0;
			rv_q     <= '0;
			st_q     <= STS_DONE;
			mdata_q  <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			mvalid_q <= mvalid_d;
			idx_q    <= idx_d;
			tgt_q    <= tgt_d;
			del_q    <= del_d;
			val_q    <= val_d;
			rv_q     <= rv_d;
			st_q     <= st_d;
			mdata_q  <= mdata_d;
		end
	end

endmodule

/* hw/rtl/indexed_list_engine.sv */
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Input channel s_*: one command item (read, insert front, append, insert at
// position, delete at position). Output channel m_*: exactly one result item
// per command, in order: read_value, status, entry_count after the command.
// Values live in one single-port-write, registered-read memory; a sequencer
// reads, shifts and writes it back one entry per cycle.
// Steps per command: append, insert at the tail, refused or unused commands
// and delete of the last entry go from the taking state straight to loading
// the result; a read passes through RD_WAIT (one memory read); insert at
// position p below count moves each entry from p on up one slot in SHIFT,
// writes the new value in PUT_VAL, then loads the result; delete at position
// p below count - 1 moves each later entry down one slot in SHIFT, then loads
// the result. s_tready returns the cycle after the result is loaded. Reset
// clears the count and the output valid; memory contents stay as they are and
// are never read before written. When m_tready stays low, one result waits at
// m_*, the next command runs and then holds in the sequencer, and no further
// item is taken.
module indexed_list_engine #(
	parameter int unsigned CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// cmd[2:0], position[14:3], value[46:15], zero fill above
	input  logic [ile_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// read_value[31:0], status[33:32], entry_count[44:34], zero fill above
	output logic [ile_pkg::M_TDATA_W-1:0] m_tdata
);
	import ile_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);

	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;

	ile_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ile_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result fields for checks
	logic [DATA_W-1:0]  m_rv;
	logic [STAT_W-1:0]  m_st;
	logic [CNT_O_W-1:0] m_cnt;

	assign m_rv  = m_tdata[OUT_RV_LO +: DATA_W];
	assign m_st  = m_tdata[OUT_ST_LO +: STAT_W];
	assign m_cnt = m_tdata[OUT_CNT_LO +: CNT_O_W];

	// a taken command moves the sequencer out of IDLE, so items are never taken back to back
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted on back-to-back cycles");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_st == STS_DONE || m_st == STS_RANGE || m_st == STS_FULL))
		else $error("unknown status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_st == STS_FULL) |-> (m_cnt == CNT_O_W'(CAPACITY)))
		else $error("full refusal with count below capacity");

	a_range_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_st == STS_RANGE) |-> (m_rv == '1 || m_rv == '0))
		else $error("rejected command carries a data value");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CAPACITY > 2047 || 32'(m_cnt) <= CAPACITY))
		else $error("entry count above capacity");

endmodule

/* tb/indexed_list_engine_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for indexed_list_engine: every command item is fed to an
// in-bench list predictor at acceptance, and each result item is compared
// field by field against the oldest predicted reply.
module indexed_list_engine_test;

	import ile_pkg::*;

	localparam int LIST_CAP   = CAPACITY_DEF;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int LONG_HOLD  = 400;  // receiver hold-off used for the pressure test
	localparam int MAX_RANDOM_LEN = 48;  // keeps random-phase shifts short
	localparam int LONG_LEN   = 120;  // list length reached by the long-list test
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef struct {
		logic [DATA_W-1:0]  read_value;
		logic [STAT_W-1:0]  status;
		logic [CNT_O_W-1:0] entry_count;
	} list_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// predictor state: list contents and length
	logic [DATA_W-1:0] list_mem [LIST_CAP];
	int                list_len = 0;
	list_reply_t       replies_due[$];

	int fail_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_taken = 0;
	int hold_left = 0;
	list_reply_t want;

	indexed_list_engine #(
		.CAPACITY(LIST_CAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	// opens slot p and stores v, shifting later entries back
	function automatic void list_insert(int p, logic [DATA_W-1:0] v);
		for (int i = list_len; i > p; i--)
			list_mem[i] = list_mem[i-1];
		list_mem[p] = v;
		list_len++;
	endfunction

	// applies one command to the predicted list and returns the reply it gives
	function automatic list_reply_t apply_list_command(logic [CMD_W-1:0] cmd,
			logic [POS_W-1:0] pos_bits, logic [DATA_W-1:0] val);
		list_reply_t r;
		logic signed [POS_W-1:0] spos;
		int p;
		bit fits_read;
		bit fits_ins;
		bit is_full;
		spos = pos_bits;
		p = spos;
		fits_read = (p >= 0) && (p < list_len);
		fits_ins = (p >= 0) && (p <= list_len);
		is_full = list_len >= LIST_CAP;
		r.read_value = '0;
		r.status = STS_DONE;
		case (cmd)
			CMD_READ: begin
				if (fits_read) begin
					r.read_value = list_mem[p];
				end else begin
					r.read_value = '1;
					r.status = STS_RANGE;
				end
			end
			CMD_INS_FRONT: begin
				if (is_full) r.status = STS_FULL;
				else list_insert(0, val);
			end
			CMD_APPEND: begin
				if (is_full) r.status = STS_FULL;
				else list_insert(list_len, val);
			end
			CMD_INS_POS: begin
				// range is checked ahead of fullness
				if (!fits_ins) r.status = STS_RANGE;
				else if (is_full) r.status = STS_FULL;
				else list_insert(p, val);
			end
			CMD_DELETE: begin
				if (!fits_read) begin
					r.status = STS_RANGE;
				end else begin
					for (int i = p; i < list_len - 1; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			default: ;  // unused codes leave the list alone
		endcase
		r.entry_count = list_len[CNT_O_W-1:0];
		return r;
	endfunction

	// offers one command item, with random idle cycles ahead of it, and
	// records the predicted reply once the item is taken
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [DATA_W-1:0] val);
		logic [S_TDATA_W-1:0] word;
		word = '0;
		word[IN_CMD_LO +: CMD_W] = cmd;
		word[IN_POS_LO +: POS_W] = pos;
		word[IN_VAL_LO +: DATA_W] = val;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do
			@(posedge clk);
		while (!s_tready);
		replies_due.push_back(apply_list_command(cmd, pos, val));
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) != 0)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// mostly valid positions, some at the edges, a few anywhere in the field
	function automatic logic [POS_W-1:0] pick_position();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 80)
			return POS_W'($urandom_range(0, list_len));
		if (mode < 90) begin
			case ($urandom_range(0, 2))
				0: return '1;
				1: return POS_W'(list_len);
				default: return POS_W'(list_len + 1);
			endcase
		end
		return POS_W'($urandom);
	endfunction

	// extremes of the fields and every command on a tiny list
	task automatic test_directed();
		send_item(CMD_READ, 0, 0);             // read of empty list
		send_item(CMD_DELETE, 0, 0);           // delete from empty list
		send_item(CMD_INS_POS, 1, 32'h1234_5678);  // past the end
		send_item(CMD_INS_POS, '1, 32'h1234_5678); // negative position
		send_item(CMD_INS_POS, 0, 32'h0000_0000);  // position equal to count appends
		send_item(CMD_APPEND, 0, 32'h7FFF_FFFF);
		send_item(CMD_INS_FRONT, 0, 32'h8000_0000);
		send_item(CMD_INS_POS, 1, 32'hFFFF_FFFF);
		send_item(CMD_READ, 12'h800, 0);       // most negative position
		send_item(CMD_READ, 12'h7FF, 0);       // most positive position
		for (int i = 0; i <= 4; i++)
			send_item(CMD_READ, POS_W'(i), 32'hFFFF_FFFF);  // last one is at count
		send_item(CMD_DELETE, 3, 0);           // last entry
		send_item(CMD_DELETE, 0, 0);           // first entry
		send_item(CMD_DELETE, '1, 0);
		send_item(CMD_DELETE, 12'h7FF, 0);
		for (logic [CMD_W:0] c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			send_item(c[CMD_W-1:0], POS_W'($urandom), $urandom);
		send_item(CMD_INS_POS, POS_W'(list_len), 32'hA5A5_5A5A);
		send_item(CMD_READ, 1, 0);
	endtask

	// random command mix at one idling setting
	task automatic test_random_mix(int n, int idle_pct, int stall_pct);
		logic [CMD_W-1:0] cmd;
		int sel;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 28) cmd = CMD_READ;
			else if (sel < 43) cmd = CMD_INS_FRONT;
			else if (sel < 58) cmd = CMD_APPEND;
			else if (sel < 75) cmd = CMD_INS_POS;
			else if (sel < 94) cmd = CMD_DELETE;
			else cmd = CMD_W'(CMD_UNUSED_FIRST + $urandom_range(0, 2));
			// bound the length so shifts stay short
			if (list_len >= MAX_RANDOM_LEN &&
					(cmd == CMD_INS_FRONT || cmd == CMD_APPEND || cmd == CMD_INS_POS))
				cmd = CMD_DELETE;
			send_item(cmd, pick_position(), pick_value());
		end
	endtask

	// receiver holds off for a long stretch while commands keep coming,
	// so the engine fills up and stops taking items
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		for (int k = 0; k < 24; k++)
			send_item($urandom_range(0, 1) ? CMD_APPEND : CMD_READ,
				POS_W'($urandom_range(0, list_len)), $urandom);
	endtask

	// grows the list well past the random-phase bound, then checks deep
	// shifts both ways and the ends of the list
	task automatic test_long_list();
		send_idle_pct = 5;
		recv_stall_pct = 10;
		while (list_len < LONG_LEN)
			send_item(CMD_APPEND, 0, pick_value());
		send_item(CMD_INS_POS, 1, pick_value());       // deep shift back
		send_item(CMD_INS_FRONT, 0, pick_value());
		send_item(CMD_READ, 0, 0);
		send_item(CMD_READ, 1, 0);
		send_item(CMD_READ, POS_W'(list_len - 1), 0);
		send_item(CMD_READ, POS_W'(list_len), 0);
		send_item(CMD_INS_POS, POS_W'(list_len + 1), pick_value()); // past the end
		send_item(CMD_DELETE, POS_W'(list_len), 0);
		send_item(CMD_DELETE, 0, 0);                   // deep shift forward
		send_item(CMD_DELETE, POS_W'(list_len - 1), 0);
		for (int i = 0; i < 4; i++)
			send_item(CMD_READ, POS_W'($urandom_range(0, list_len)), 0);
	endtask

	// receiver: random stalls, or a counted hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_requests != hold_taken) begin
			hold_taken = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result checker: each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %h",
					$time, m_tdata);
				fail_count++;
			end else begin
				want = replies_due.pop_front();
				if (m_tdata[OUT_RV_LO +: DATA_W] !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						want.read_value, m_tdata[OUT_RV_LO +: DATA_W]);
					fail_count++;
				end
				if (m_tdata[OUT_ST_LO +: STAT_W] !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, m_tdata[OUT_ST_LO +: STAT_W]);
					fail_count++;
				end
				if (m_tdata[OUT_CNT_LO +: CNT_O_W] !== want.entry_count) begin
					$display("%0t: entry_count expected %0d actual %0d", $time,
						want.entry_count, m_tdata[OUT_CNT_LO +: CNT_O_W]);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("indexed_list_engine verification failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(80, 0, 0);
		test_random_mix(80, 66, 0);
		test_backpressure();
		test_random_mix(80, 0, 66);
		test_long_list();
		test_random_mix(80, 36, 36);
		s_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("indexed_list_engine verification clean");
		else
			$display("indexed_list_engine verification failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/ile_pkg.sv
hw/rtl/ile_store.sv
hw/rtl/ile_ctrl.sv
hw/rtl/indexed_list_engine.sv
tb/indexed_list_engine_test.sv
